@@ sv/onewire_temperature_read_master_assert.svh @@
// Assertion macros for the single-wire temperature read master.
// Used by the top level; expects clk and arst_n in scope.
`ifndef ONEWIRE_TEMPERATURE_READ_MASTER_ASSERT_SVH
`define ONEWIRE_TEMPERATURE_READ_MASTER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define OWTR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define OWTR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/owtr_pkg.sv @@
// Shared types and constants for the single-wire temperature read master.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package owtr_pkg;

	localparam int TL_W      = 20;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 20;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SMP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERT_WAIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_SHORT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_LONG      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL      = 3'd7;

	// Register reset values
	localparam logic [9:0]  RST_RESET_LOW_US      = 10'd600;
	localparam logic [7:0]  RST_PRESENCE_SMP_US   = 8'd80;
	localparam logic [9:0]  RST_RESET_TAIL_US     = 10'd500;
	localparam logic [19:0] RST_CONVERT_WAIT_US   = 20'd750000;
	localparam logic [5:0]  RST_SLOT_SHORT_US     = 6'd2;
	localparam logic [7:0]  RST_SLOT_LONG_US      = 8'd80;
	localparam logic [5:0]  RST_READ_SAMPLE_US    = 6'd10;
	localparam logic [7:0]  RST_READ_TAIL_US      = 8'd50;

	// Bus command bytes
	localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_PAD = 8'hBE;

	// Command steps
	localparam logic [2:0] STEP_CONVERT    = 3'd1;
	localparam logic [2:0] STEP_CONV_WAIT  = 3'd2;
	localparam logic [2:0] STEP_READ_PAD   = 3'd3;
	localparam logic [2:0] STEP_FIRST_READ = 3'd4;
	localparam logic [2:0] STEP_LAST       = 3'd6;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_RST_LOW  = 5'd1,
		PH_RST_REL  = 5'd2,
		PH_RST_TAIL = 5'd3,
		PH_WR_LOW   = 5'd4,
		PH_WR_REL   = 5'd5,
		PH_CONV     = 5'd6,
		PH_RD_LOW   = 5'd7,
		PH_RD_REL   = 5'd8,
		PH_RD_TAIL  = 5'd9
	} phase_t;

	typedef struct packed {
		logic command;
		logic line_level;
	} req_t;

	typedef struct packed {
		logic        drive_low;
		logic        busy_res;
		logic        done_res;
		logic        no_presence;
		logic [15:0] temp_data;
	} rsp_t;

	typedef struct packed {
		logic [9:0]  reset_low_us;
		logic [7:0]  presence_sample_us;
		logic [9:0]  reset_tail_us;
		logic [19:0] convert_wait_us;
		logic [5:0]  slot_short_us;
		logic [7:0]  slot_long_us;
		logic [5:0]  read_sample_us;
		logic [7:0]  read_tail_us;
	} cfg_t;

	typedef struct packed {
		logic idle;
	} stat_t;

endpackage

@@ sv/onewire_temperature_read_master.sv @@
// Single-wire bus master for one temperature read. Every request is one
// microsecond tick carrying a start command and the sampled line level;
// every request yields exactly one response with the line drive, busy,
// done, no-presence flag and, at the end of a good read, the raw 16-bit
// temperature word. A start runs reset/presence, skip-ROM + convert, a
// conversion wait, a second reset/presence, skip-ROM + read-scratchpad and
// sixteen read slots, all timed by the eight timing registers. The line is
// open drain: drive_low pulls it low, otherwise it is released to the
// pull-up. Throughput is one request per clock cycle, sustained while
// rsp_ready does not stall the response register; the input register
// takes the request, and the one-tick sequencer then runs it into the
// response register.
// Timing registers are written through the cfg channel (always ready) and
// should only be written while no sequence is running; a value written is
// picked up the next time its phase is entered.
// Depends on owtr_pkg, owtr_cfg, owtr_core and the assertion macro header.
`timescale 1ns / 1ps

`include "onewire_temperature_read_master_assert.svh"

module onewire_temperature_read_master
	import owtr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// tick requests
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	// responses
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	// timing register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cfg_t  cfg;
	rsp_t  step_res;
	stat_t stat;

	// input stage
	logic vld_s1;
	req_t item_s1;

	// response register
	logic rsp_vld_q;
	rsp_t rsp_q;

	logic out_free;
	logic adv;

	// response slot is free when empty or being drained this cycle
	assign out_free  = !rsp_vld_q || rsp_ready;
	// the tick in the input stage is executed exactly when it moves on
	assign adv       = vld_s1 && out_free;
	assign req_ready = !vld_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_free) begin
			rsp_vld_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= step_res;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	owtr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owtr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (step_res),
		.stat   (stat)
	);

	// a stalled tick must not drop out of the input stage
	`OWTR_ASSERT_NEXT(a_s1_hold, vld_s1 && !out_free, vld_s1, "input stage lost a stalled tick")
	// a finishing tick leaves the sequencer idle
	`OWTR_ASSERT_NEXT(a_done_idle, adv && step_res.done_res, stat.idle, "sequencer not idle after done")
	// an executed tick always shows up as a response next cycle
	`OWTR_ASSERT_NEXT(a_adv_rsp, adv, rsp_valid, "executed tick produced no response")
	// temperature word only on a good finish
	`OWTR_ASSERT_NOW(a_temp_done, rsp_valid && (rsp.temp_data != 16'd0),
		rsp.done_res && !rsp.no_presence, "temperature word outside a good finish")

endmodule

@@ sv/owtr_cfg.sv @@
// Timing register file of the single-wire temperature read master.
// Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_cfg
	import owtr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us       <= RST_RESET_LOW_US;
			cfg_q.presence_sample_us <= RST_PRESENCE_SMP_US;
			cfg_q.reset_tail_us      <= RST_RESET_TAIL_US;
			cfg_q.convert_wait_us    <= RST_CONVERT_WAIT_US;
			cfg_q.slot_short_us      <= RST_SLOT_SHORT_US;
			cfg_q.slot_long_us       <= RST_SLOT_LONG_US;
			cfg_q.read_sample_us     <= RST_READ_SAMPLE_US;
			cfg_q.read_tail_us       <= RST_READ_TAIL_US;
		end else if (wr_en) begin
			case (wr_index)
				REG_RESET_LOW:    cfg_q.reset_low_us       <= wr_data[9:0];
				REG_PRESENCE_SMP: cfg_q.presence_sample_us <= wr_data[7:0];
				REG_RESET_TAIL:   cfg_q.reset_tail_us      <= wr_data[9:0];
				REG_CONVERT_WAIT: cfg_q.convert_wait_us    <= wr_data[19:0];
				REG_SLOT_SHORT:   cfg_q.slot_short_us      <= wr_data[5:0];
				REG_SLOT_LONG:    cfg_q.slot_long_us       <= wr_data[7:0];
				REG_READ_SAMPLE:  cfg_q.read_sample_us     <= wr_data[5:0];
				REG_READ_TAIL:    cfg_q.read_tail_us       <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/owtr_core.sv @@
// Sequencer of the single-wire temperature read master: state registers
// plus the one-tick next-state and result logic. Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_core
	import owtr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  req_t  item,
	input  cfg_t  cfg,
	output rsp_t  res,
	output stat_t stat
);

	phase_t          ph_q;
	logic [TL_W-1:0] tl_q;
	logic [7:0]      sb_q;
	logic [2:0]      bc_q;
	logic [2:0]      cs_q;
	logic [15:0]     tw_q;
	logic            er_q;

	phase_t          ph_n;
	logic [TL_W-1:0] tl_n;
	logic [7:0]      sb_n;
	logic [2:0]      bc_n;
	logic [2:0]      cs_n;
	logic [15:0]     tw_n;
	logic            er_n;
	logic            last;

	always_comb begin
		ph_n = ph_q;
		tl_n = tl_q;
		sb_n = sb_q;
		bc_n = bc_q;
		cs_n = cs_q;
		tw_n = tw_q;
		er_n = er_q;
		res  = '0;
		last = 1'b0;

		// start only from idle
		if (ph_n == PH_IDLE && item.command) begin
			tw_n = '0;
			cs_n = '0;
			bc_n = '0;
			sb_n = '0;
			er_n = 1'b0;
			ph_n = PH_RST_LOW;
			tl_n = TL_W'(cfg.reset_low_us);
		end

		if (ph_n != PH_IDLE) begin
			res.busy_res = 1'b1;
			// zero and one both last a single tick
			last = (tl_n <= TL_W'(1));
			if (!last) begin
				tl_n = tl_n - TL_W'(1);
			end
			case (ph_n)
				PH_RST_LOW: begin
					res.drive_low = 1'b1;
					if (last) begin
						ph_n = PH_RST_REL;
						tl_n = TL_W'(cfg.presence_sample_us);
					end
				end
				PH_RST_REL: begin
					if (last) begin
						er_n = item.line_level;
						ph_n = PH_RST_TAIL;
						tl_n = TL_W'(cfg.reset_tail_us);
					end
				end
				PH_RST_TAIL: begin
					if (last) begin
						if (er_n) begin
							res.done_res    = 1'b1;
							res.no_presence = 1'b1;
							ph_n = PH_IDLE;
							tl_n = '0;
						end else begin
							case (cs_n)
								STEP_CONVERT:  sb_n = CMD_CONVERT;
								STEP_READ_PAD: sb_n = CMD_READ_PAD;
								default:       sb_n = CMD_SKIP_ROM;
							endcase
							bc_n = '0;
							ph_n = PH_WR_LOW;
							tl_n = sb_n[0] ? TL_W'(cfg.slot_short_us) : TL_W'(cfg.slot_long_us);
						end
					end
				end
				PH_WR_LOW: begin
					res.drive_low = 1'b1;
					if (last) begin
						ph_n = PH_WR_REL;
						tl_n = sb_n[0] ? TL_W'(cfg.slot_long_us) : TL_W'(cfg.slot_short_us);
					end
				end
				PH_WR_REL: begin
					if (last) begin
						sb_n = sb_n >> 1;
						bc_n = bc_n + 3'd1;
						if (bc_n != 3'd0) begin
							ph_n = PH_WR_LOW;
							tl_n = sb_n[0] ? TL_W'(cfg.slot_short_us) : TL_W'(cfg.slot_long_us);
						end else begin
							cs_n = cs_n + 3'd1;
							if (cs_n == STEP_CONV_WAIT) begin
								ph_n = PH_CONV;
								tl_n = cfg.convert_wait_us;
							end else if (cs_n >= STEP_FIRST_READ) begin
								ph_n = PH_RD_LOW;
								tl_n = TL_W'(cfg.slot_short_us);
							end else begin
								case (cs_n)
									STEP_CONVERT:  sb_n = CMD_CONVERT;
									STEP_READ_PAD: sb_n = CMD_READ_PAD;
									default:       sb_n = CMD_SKIP_ROM;
								endcase
								bc_n = '0;
								ph_n = PH_WR_LOW;
								tl_n = sb_n[0] ? TL_W'(cfg.slot_short_us)
									: TL_W'(cfg.slot_long_us);
							end
						end
					end
				end
				PH_CONV: begin
					if (last) begin
						ph_n = PH_RST_LOW;
						tl_n = TL_W'(cfg.reset_low_us);
					end
				end
				PH_RD_LOW: begin
					res.drive_low = 1'b1;
					if (last) begin
						ph_n = PH_RD_REL;
						tl_n = TL_W'(cfg.read_sample_us);
					end
				end
				PH_RD_REL: begin
					if (last) begin
						// LSB first: shift in from the top
						tw_n = {item.line_level, tw_n[15:1]};
						ph_n = PH_RD_TAIL;
						tl_n = TL_W'(cfg.read_tail_us);
					end
				end
				PH_RD_TAIL: begin
					if (last) begin
						bc_n = bc_n + 3'd1;
						if (bc_n == 3'd0) begin
							cs_n = cs_n + 3'd1;
						end
						if (cs_n >= STEP_LAST) begin
							res.done_res  = 1'b1;
							res.temp_data = tw_n;
							ph_n = PH_IDLE;
							tl_n = '0;
						end else begin
							ph_n = PH_RD_LOW;
							tl_n = TL_W'(cfg.slot_short_us);
						end
					end
				end
				default: begin
					ph_n = PH_IDLE;
					tl_n = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			tl_q <= '0;
			sb_q <= '0;
			bc_q <= '0;
			cs_q <= '0;
			tw_q <= '0;
			er_q <= 1'b0;
		end else if (step) begin
			ph_q <= ph_n;
			tl_q <= tl_n;
			sb_q <= sb_n;
			bc_q <= bc_n;
			cs_q <= cs_n;
			tw_q <= tw_n;
			er_q <= er_n;
		end
	end

	assign stat.idle = (ph_q == PH_IDLE);

endmodule
